@@ hdl/bstk_pkg.sv @@
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared types and constants for the bounded stack with search.
// ----------------------------------------------------------------------------
package bstk_pkg;

    // Default number of stack entries
    localparam int DEPTH_DEFAULT = 8;

    // Command codes carried by an input item
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_FIND  = 2'd3
    } cmd_e;

    // Status codes carried by a result item
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_e;

    // One input item
    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [2:0] match_index;
        logic [3:0] fill_count;
    } out_item_t;

endpackage

@@ hdl/bstk_mem.sv @@
// ----------------------------------------------------------------------------
// bstk_mem
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bstk_mem #(
    parameter int DEPTH = bstk_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [31:0]  rd_data
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    // Write the new top word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data valid in the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/bstk_ctrl.sv @@
// ----------------------------------------------------------------------------
// bstk_ctrl
// Command sequencer: decodes an item, updates the level, drives the entry
// store and scans it from the top down for a find.
// ----------------------------------------------------------------------------
module bstk_ctrl #(
    parameter int DEPTH = bstk_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int LW    = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    // input items
    input  logic                in_valid,
    output logic                in_ready,
    input  bstk_pkg::in_item_t  in_item,
    // finished results
    output logic                res_valid,
    input  logic                res_ready,
    output bstk_pkg::out_item_t res_item,
    // entry store
    output logic                mem_wr_en,
    output logic [AW-1:0]       mem_wr_addr,
    output logic signed [31:0]  mem_wr_data,
    output logic                mem_rd_en,
    output logic [AW-1:0]       mem_rd_addr,
    input  logic signed [31:0]  mem_rd_data
);

    localparam logic [LW-1:0] LEVEL_FULL = LW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_e;

    state_e              state_reg, state_next;
    logic [LW-1:0]       level_reg, level_next;
    logic [AW-1:0]       k_reg, k_next;
    logic signed [31:0]  value_reg, value_next;
    bstk_pkg::out_item_t res_reg, res_next;

    logic [LW-1:0]       level_dec;
    logic [LW+3:0]       fill_wide;
    logic [AW+2:0]       idx_wide;
    logic [3:0]          fill_now;

    assign level_dec = level_reg - 1'b1;
    assign fill_wide = {4'b0000, level_next};
    assign fill_now  = fill_wide[3:0];
    assign idx_wide  = {3'b000, k_reg};

    assign in_ready    = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res_item    = res_reg;
    assign mem_wr_addr = level_reg[AW-1:0];
    assign mem_wr_data = in_item.value;

    // Decode the item and step the scan
    always_comb
    begin
        state_next  = state_reg;
        level_next  = level_reg;
        k_next      = k_reg;
        value_next  = value_reg;
        res_next    = res_reg;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = k_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next.status      = bstk_pkg::ST_OK;
                    res_next.found       = 1'b0;
                    res_next.match_index = 3'd0;
                    state_next           = S_DONE;
                    unique case (in_item.command)
                        bstk_pkg::CMD_PUSH:
                        begin
                            if (level_reg == LEVEL_FULL)
                            begin
                                res_next.status = bstk_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en  = 1'b1;
                                level_next = level_reg + 1'b1;
                            end
                        end
                        bstk_pkg::CMD_POP:
                        begin
                            if (level_reg == '0)
                            begin
                                res_next.status = bstk_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                level_next = level_dec;
                            end
                        end
                        bstk_pkg::CMD_CLEAR:
                        begin
                            level_next = '0;
                        end
                        bstk_pkg::CMD_FIND:
                        begin
                            if (level_reg == '0)
                            begin
                                res_next.status = bstk_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // start the scan at the top entry
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = level_dec[AW-1:0];
                                k_next      = level_dec[AW-1:0];
                                value_next  = in_item.value;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                    res_next.fill_count = fill_now;
                end
            end

            S_SCAN:
            begin
                res_next.fill_count = fill_now;
                if (mem_rd_data == value_reg)
                begin
                    res_next.found       = 1'b1;
                    res_next.match_index = idx_wide[2:0];
                    state_next           = S_DONE;
                end
                else if (k_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // fetch the next entry down
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = k_reg - 1'b1;
                    k_next      = k_reg - 1'b1;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, level and the pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            level_reg <= '0;
            k_reg     <= '0;
            value_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            k_reg     <= k_next;
            value_reg <= value_next;
            res_reg   <= res_next;
        end
    end

endmodule

@@ hdl/bounded_stack_with_search_top.sv @@
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// Bounded LIFO stack of signed 32-bit words with a top-down search.
// ----------------------------------------------------------------------------
// One item is processed at a time. Push, pop and clear write their result
// into the sequencer's result register and then into the output register.
// Find reads one stored entry per cycle through the single read port of the
// entry memory, starting at the top, until it hits a match or has compared
// the bottom entry. A new item is accepted as soon as the previous result
// has moved into the output register, even while that result still waits
// to be taken. Entries are not cleared at reset; only the level is.
module bounded_stack_with_search_top #(
    parameter int DEPTH = bstk_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bstk_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output bstk_pkg::out_item_t out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic signed [31:0]  mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic signed [31:0]  mem_rd_data;

    logic                res_valid;
    logic                res_ready;
    bstk_pkg::out_item_t res_item;

    logic                out_valid_reg;
    bstk_pkg::out_item_t out_item_reg;

    bstk_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .LW    (LW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_item    (res_item),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    bstk_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Take a result when the output register is free or being emptied
    assign res_ready = !out_valid_reg || out_ready;

    // Hold the result item until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_item_reg <= res_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    // Only one item is in flight: accepting one closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in progress");

    // A hit is only reported with an ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.found) |-> (out_item.status == bstk_pkg::ST_OK))
        else $error("found set on a refused command");

    // A refusal for an empty stack reports an empty stack and no hit
    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status == bstk_pkg::ST_EMPTY)
        |-> (out_item.fill_count == 4'd0 && !out_item.found
             && out_item.match_index == 3'd0))
        else $error("empty refusal with nonzero fill count or hit");
`endif

endmodule

@@ bench/bstk_checker.sv @@
// ----------------------------------------------------------------------------
// bstk_checker
// Watches both channels of the bounded stack, keeps its own copy of the
// stack, predicts the result of every accepted item and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bstk_checker #(
    parameter int DEPTH = bstk_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  bstk_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_ready,
    input  bstk_pkg::out_item_t out_item,
    output int                  mismatch_count,
    output int                  results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the stack
    logic [31:0] shadow_words [DEPTH];
    int          shadow_level;

    // Predicted results, oldest first
    bstk_pkg::out_item_t predicted_results[$];
    bstk_pkg::out_item_t want;

    // Apply one command to the shadow stack and return its result
    function automatic bstk_pkg::out_item_t stack_apply(bstk_pkg::in_item_t it);
        bstk_pkg::out_item_t r;
        int                  k;
        r = '0;
        r.status = bstk_pkg::ST_OK;
        case (bstk_pkg::cmd_e'(it.command))
            bstk_pkg::CMD_PUSH:
            begin
                if (shadow_level >= DEPTH)
                    r.status = bstk_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_level] = it.value;
                    shadow_level++;
                end
            end
            bstk_pkg::CMD_POP:
            begin
                if (shadow_level == 0)
                    r.status = bstk_pkg::ST_EMPTY;
                else
                    shadow_level--;
            end
            bstk_pkg::CMD_CLEAR:
            begin
                shadow_level = 0;
            end
            default:
            begin
                // search from the top entry down, stop at the first hit
                if (shadow_level == 0)
                    r.status = bstk_pkg::ST_EMPTY;
                else
                begin
                    for (k = shadow_level - 1; k >= 0 && !r.found; k--)
                    begin
                        if (shadow_words[k] == it.value)
                        begin
                            r.found       = 1'b1;
                            r.match_index = 3'(k);
                        end
                    end
                end
            end
        endcase
        r.fill_count = 4'(shadow_level);
        return r;
    endfunction

    // Count a failure, report only the first few
    task automatic note_failure(string what, bstk_pkg::out_item_t exp_r,
                                bstk_pkg::out_item_t got_r);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected status=%0d found=%0d index=%0d fill=%0d,",
                     $time, what, exp_r.status, exp_r.found, exp_r.match_index,
                     exp_r.fill_count,
                     " got status=%0d found=%0d index=%0d fill=%0d",
                     got_r.status, got_r.found, got_r.match_index,
                     got_r.fill_count);
    endtask

    // Compare results first, then record the prediction for a new item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_level = 0;
            predicted_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                    note_failure("unexpected result", '0, out_item);
                else
                begin
                    want = predicted_results.pop_front();
                    if (out_item.status !== want.status ||
                        out_item.found !== want.found ||
                        out_item.match_index !== want.match_index ||
                        out_item.fill_count !== want.fill_count)
                        note_failure("result mismatch", want, out_item);
                end
            end
            if (in_valid && in_ready)
                predicted_results.push_back(stack_apply(in_item));
        end
        results_owed = predicted_results.size();
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the bounded stack with a directed set of edge cases and then with
// phases of random commands biased toward filling, draining or mixing, with
// random idling on both channels, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    bstk_pkg::in_item_t  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    bstk_pkg::out_item_t out_item;

    int        mismatch_count;
    int        results_owed;

    // Stimulus controls shared with the receiver
    bit        steady   = 1'b0;
    bit        hold_req = 1'b0;

    // Recently pushed words, used as search keys
    logic [31:0] pushed_words [8];
    int          push_slot = 0;

    bounded_stack_with_search_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    bstk_checker stack_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one item, idling first at random; valid stays high after accept
    task automatic offer_item(bstk_pkg::cmd_e c, logic [31:0] v);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 37)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= '{command: c, value: v};
        if (c == bstk_pkg::CMD_PUSH)
        begin
            pushed_words[push_slot] = v;
            push_slot = (push_slot + 1) % 8;
        end
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_owed == 0);
    endtask

    // Random word: extremes, small repeats for duplicates, or full range
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5, 6: return $urandom();
            default: return 32'($urandom_range(0, 5));
        endcase
    endfunction

    // Command mix by phase: fill heavy, drain heavy, or mixed
    function automatic bstk_pkg::cmd_e pick_command(int mode);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        case (mode)
            0:
            begin
                push_pct = 60;
                pop_pct  = 10;
            end
            1:
            begin
                push_pct = 20;
                pop_pct  = 45;
            end
            default:
            begin
                push_pct = 40;
                pop_pct  = 25;
            end
        endcase
        if (roll < push_pct)
            return bstk_pkg::CMD_PUSH;
        else if (roll < push_pct + pop_pct)
            return bstk_pkg::CMD_POP;
        else if (roll < push_pct + pop_pct + 5)
            return bstk_pkg::CMD_CLEAR;
        else
            return bstk_pkg::CMD_FIND;
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (250) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    // Stimulus and verdict
    initial
    begin
        bstk_pkg::cmd_e c;
        logic [31:0]    v;

        foreach (pushed_words[i])
            pushed_words[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refusals and a clear on an empty stack, then fill to full with duplicates
        offer_item(bstk_pkg::CMD_POP,   $urandom());
        offer_item(bstk_pkg::CMD_FIND,  32'h0000_0000);
        offer_item(bstk_pkg::CMD_CLEAR, $urandom());
        offer_item(bstk_pkg::CMD_PUSH,  32'h7fff_ffff);
        offer_item(bstk_pkg::CMD_PUSH,  32'h8000_0000);
        offer_item(bstk_pkg::CMD_PUSH,  32'h0000_0000);
        offer_item(bstk_pkg::CMD_PUSH,  32'hffff_ffff);
        offer_item(bstk_pkg::CMD_PUSH,  32'h0000_0005);
        offer_item(bstk_pkg::CMD_PUSH,  32'hffff_ffff);
        offer_item(bstk_pkg::CMD_PUSH,  32'h0000_0005);
        offer_item(bstk_pkg::CMD_PUSH,  32'h8000_0000);
        // push on a full stack is refused
        offer_item(bstk_pkg::CMD_PUSH,  32'h0000_0001);
        // topmost duplicate, bottom entry, top entry, no match
        offer_item(bstk_pkg::CMD_FIND,  32'hffff_ffff);
        offer_item(bstk_pkg::CMD_FIND,  32'h7fff_ffff);
        offer_item(bstk_pkg::CMD_FIND,  32'h8000_0000);
        offer_item(bstk_pkg::CMD_FIND,  32'h0000_007b);
        offer_item(bstk_pkg::CMD_POP,   $urandom());
        offer_item(bstk_pkg::CMD_CLEAR, $urandom());
        offer_item(bstk_pkg::CMD_FIND,  32'hffff_ffff);
        // after clear the bottom entry is overwritten; its old word must not match
        offer_item(bstk_pkg::CMD_PUSH,  32'h0000_0009);
        offer_item(bstk_pkg::CMD_FIND,  32'h7fff_ffff);
        offer_item(bstk_pkg::CMD_POP,   $urandom());
        offer_item(bstk_pkg::CMD_POP,   $urandom());
        drain_results();

        // Random phases
        for (int phase = 0; phase < 10; phase++)
        begin
            steady = (phase == 2);
            if (phase == 4)
                hold_req = 1'b1;
            if (phase == 6)
                drain_results();
            for (int n = 0; n < 115; n++)
            begin
                c = pick_command(phase % 3);
                if (c == bstk_pkg::CMD_FIND && $urandom_range(0, 99) < 60)
                    v = pushed_words[$urandom_range(0, 7)];
                else
                    v = pick_word();
                offer_item(c, v);
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bstk_pkg.sv
hdl/bstk_mem.sv
hdl/bstk_ctrl.sv
hdl/bounded_stack_with_search_top.sv
bench/bstk_checker.sv
bench/tb.sv
